@@ rtl/core/unp_pkg.sv @@
// Shared types and constants for the unit normal pack/unpack block.
// Used by unp_enc, unp_dec and unit_normal_pack_unpack.
package unp_pkg;

  // Request codes
  localparam logic REQ_ENCODE = 1'b0;
  localparam logic REQ_DECODE = 1'b1;

  // Pipeline geometry
  localparam int unsigned ENC_SQRT_STEPS = 16;
  localparam int unsigned DIV_STEPS      = 25;
  localparam int unsigned DEC_SQRT_STEPS = 31;
  localparam int unsigned ENC_LAT        = ENC_SQRT_STEPS + DIV_STEPS + 2;
  localparam int unsigned DEC_CORE_LAT   = 3 + DEC_SQRT_STEPS + 2;
  localparam int unsigned DEC_PAD        = ENC_LAT - DEC_CORE_LAT;

  // Arithmetic constants
  localparam logic [24:0]        M_MAX     = 25'h1FF_FFFF;
  localparam logic signed [41:0] Q_CLAMP   = 42'sd4294963001;
  localparam logic [48:0]        QUANT     = 49'd32767;
  localparam logic [31:0]        DEC_RECIP = 32'd32769;

  typedef struct packed {
    logic               req_type;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [31:0]        packed_code;
  } unp_in_t;

  typedef struct packed {
    logic [31:0]        code_out;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
  } unp_out_t;

endpackage

@@ rtl/core/unp_enc.sv @@
// Encode pipeline: root of (1+nx)/2, reciprocal by restoring division,
// scale, clamp and quantize ny/nz into a 16+16 bit code. Uses unp_pkg.
module unp_enc (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             vld_i,
  input  unp_pkg::unp_in_t in_i,
  output logic             vld_o,
  output logic             req_o,
  output logic [31:0]      code_o
);
  import unp_pkg::*;

  // Square root stages
  logic [31:0]        sq_v_in  [ENC_SQRT_STEPS];
  logic [31:0]        sq_r_in  [ENC_SQRT_STEPS];
  logic               sq_vl_in [ENC_SQRT_STEPS];
  logic               sq_rq_in [ENC_SQRT_STEPS];
  logic signed [15:0] sq_y_in  [ENC_SQRT_STEPS];
  logic signed [15:0] sq_z_in  [ENC_SQRT_STEPS];
  logic [31:0]        sq_v_r   [ENC_SQRT_STEPS];
  logic [31:0]        sq_r_r   [ENC_SQRT_STEPS];
  logic               sq_vl_r  [ENC_SQRT_STEPS];
  logic               sq_rq_r  [ENC_SQRT_STEPS];
  logic signed [15:0] sq_y_r   [ENC_SQRT_STEPS];
  logic signed [15:0] sq_z_r   [ENC_SQRT_STEPS];

  // Division stages
  logic [15:0]        dv_rem_in [DIV_STEPS];
  logic [24:0]        dv_q_in   [DIV_STEPS];
  logic [15:0]        dv_d_in   [DIV_STEPS];
  logic               dv_z_in   [DIV_STEPS];
  logic               dv_vl_in  [DIV_STEPS];
  logic               dv_rq_in  [DIV_STEPS];
  logic signed [15:0] dv_y_in   [DIV_STEPS];
  logic signed [15:0] dv_zc_in  [DIV_STEPS];
  logic [15:0]        dv_rem_r  [DIV_STEPS];
  logic [24:0]        dv_q_r    [DIV_STEPS];
  logic [15:0]        dv_d_r    [DIV_STEPS];
  logic               dv_z_r    [DIV_STEPS];
  logic               dv_vl_r   [DIV_STEPS];
  logic               dv_rq_r   [DIV_STEPS];
  logic signed [15:0] dv_y_r    [DIV_STEPS];
  logic signed [15:0] dv_zc_r   [DIV_STEPS];

  for (genvar k = 0; k < ENC_SQRT_STEPS; k++) begin : g_sq
    localparam logic [31:0] BIT = 32'd1 << (30 - 2 * k);
    logic [31:0] trial;
    logic [31:0] v_nxt;
    logic [31:0] r_nxt;

    if (k == 0) begin : g_first
      // offset binary of nx is 32768 + nx
      assign sq_v_in[k]  = {~in_i.normal_x[15], in_i.normal_x[14:0], 16'h0000};
      assign sq_r_in[k]  = '0;
      assign sq_vl_in[k] = vld_i;
      assign sq_rq_in[k] = in_i.req_type;
      assign sq_y_in[k]  = in_i.normal_y;
      assign sq_z_in[k]  = in_i.normal_z;
    end else begin : g_next
      assign sq_v_in[k]  = sq_v_r[k-1];
      assign sq_r_in[k]  = sq_r_r[k-1];
      assign sq_vl_in[k] = sq_vl_r[k-1];
      assign sq_rq_in[k] = sq_rq_r[k-1];
      assign sq_y_in[k]  = sq_y_r[k-1];
      assign sq_z_in[k]  = sq_z_r[k-1];
    end

    // one root bit per stage
    always_comb begin
      trial = sq_r_in[k] + BIT;
      if (sq_v_in[k] >= trial) begin
        v_nxt = sq_v_in[k] - trial;
        r_nxt = (sq_r_in[k] >> 1) + BIT;
      end else begin
        v_nxt = sq_v_in[k];
        r_nxt = sq_r_in[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vl_r[k] <= 1'b0;
      end else begin
        sq_vl_r[k] <= sq_vl_in[k];
      end
      sq_v_r[k]  <= v_nxt;
      sq_r_r[k]  <= r_nxt;
      sq_rq_r[k] <= sq_rq_in[k];
      sq_y_r[k]  <= sq_y_in[k];
      sq_z_r[k]  <= sq_z_in[k];
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_dv
    logic [16:0] rs;
    logic        ge;
    logic [15:0] rem_nxt;

    if (j == 0) begin : g_first
      // 2^32 / r: the bits above quotient bit 24 leave a remainder of 128
      assign dv_rem_in[j] = 16'd128;
      assign dv_q_in[j]   = '0;
      assign dv_d_in[j]   = sq_r_r[ENC_SQRT_STEPS-1][15:0];
      assign dv_z_in[j]   = (sq_r_r[ENC_SQRT_STEPS-1] == '0);
      assign dv_vl_in[j]  = sq_vl_r[ENC_SQRT_STEPS-1];
      assign dv_rq_in[j]  = sq_rq_r[ENC_SQRT_STEPS-1];
      assign dv_y_in[j]   = sq_y_r[ENC_SQRT_STEPS-1];
      assign dv_zc_in[j]  = sq_z_r[ENC_SQRT_STEPS-1];
    end else begin : g_next
      assign dv_rem_in[j] = dv_rem_r[j-1];
      assign dv_q_in[j]   = dv_q_r[j-1];
      assign dv_d_in[j]   = dv_d_r[j-1];
      assign dv_z_in[j]   = dv_z_r[j-1];
      assign dv_vl_in[j]  = dv_vl_r[j-1];
      assign dv_rq_in[j]  = dv_rq_r[j-1];
      assign dv_y_in[j]   = dv_y_r[j-1];
      assign dv_zc_in[j]  = dv_zc_r[j-1];
    end

    // one quotient bit per stage
    always_comb begin
      rs = {dv_rem_in[j], 1'b0};
      ge = (rs >= {1'b0, dv_d_in[j]});
      if (ge) begin
        rem_nxt = 16'(rs - {1'b0, dv_d_in[j]});
      end else begin
        rem_nxt = rs[15:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vl_r[j] <= 1'b0;
      end else begin
        dv_vl_r[j] <= dv_vl_in[j];
      end
      dv_rem_r[j] <= rem_nxt;
      dv_q_r[j]   <= {dv_q_in[j][23:0], ge};
      dv_d_r[j]   <= dv_d_in[j];
      dv_z_r[j]   <= dv_z_in[j];
      dv_rq_r[j]  <= dv_rq_in[j];
      dv_y_r[j]   <= dv_y_in[j];
      dv_zc_r[j]  <= dv_zc_in[j];
    end
  end

  // Scale stage
  logic [24:0]        m;
  logic signed [41:0] p1_nxt, p2_nxt;
  logic signed [41:0] p1_r, p2_r;
  logic               mu_vl_r, mu_rq_r;

  always_comb begin
    m      = dv_z_r[DIV_STEPS-1] ? M_MAX : dv_q_r[DIV_STEPS-1];
    p1_nxt = dv_y_r[DIV_STEPS-1] * $signed({1'b0, m});
    p2_nxt = dv_zc_r[DIV_STEPS-1] * $signed({1'b0, m});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_vl_r <= 1'b0;
    end else begin
      mu_vl_r <= dv_vl_r[DIV_STEPS-1];
    end
    mu_rq_r <= dv_rq_r[DIV_STEPS-1];
    p1_r    <= p1_nxt;
    p2_r    <= p2_nxt;
  end

  // clamp to +-0.999999 and quantize (q+1)*32767
  function automatic logic [15:0] quant(input logic signed [41:0] p);
    logic signed [41:0] pc;
    logic [33:0]        u;
    logic [48:0]        prod;
    if (p > Q_CLAMP) begin
      pc = Q_CLAMP;
    end else if (p < -Q_CLAMP) begin
      pc = -Q_CLAMP;
    end else begin
      pc = p;
    end
    u    = 34'(pc + 42'sd4294967296);
    prod = 49'(u) * QUANT;
    return prod[47:32];
  endfunction

  logic        qt_vl_r, qt_rq_r;
  logic [31:0] qt_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qt_vl_r <= 1'b0;
    end else begin
      qt_vl_r <= mu_vl_r;
    end
    qt_rq_r   <= mu_rq_r;
    qt_code_r <= {quant(p1_r), quant(p2_r)};
  end

  assign vld_o  = qt_vl_r;
  assign req_o  = qt_rq_r;
  assign code_o = qt_code_r;

endmodule

@@ rtl/core/unp_dec.sv @@
// Decode pipeline: dequantize the code, form 1-s and its root, scale and
// round to Q1.15, then align to the encode latency. Uses unp_pkg.
module unp_dec (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             vld_i,
  input  logic [31:0]      code_i,
  output logic             vld_o,
  output unp_pkg::unp_out_t word_o
);
  import unp_pkg::*;

  // round half up by 2^sh, saturate to Q1.15
  function automatic logic [15:0] to_q15(input logic signed [63:0] v,
                                         input int unsigned sh);
    logic signed [63:0] w;
    logic signed [63:0] r;
    w = v + (64'sd1 <<< (sh - 1));
    r = w >>> sh;
    if (r > 64'sd32767) begin
      return 16'h7FFF;
    end else if (r < -64'sd32768) begin
      return 16'h8000;
    end else begin
      return r[15:0];
    end
  endfunction

  // Dequantize
  logic [31:0]        dq1_p, dq2_p;
  logic signed [31:0] q1_r, q2_r;
  logic               s1_vl_r;

  always_comb begin
    dq1_p = 32'(code_i[31:16]) * DEC_RECIP;
    dq2_p = 32'(code_i[15:0]) * DEC_RECIP;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vl_r <= 1'b0;
    end else begin
      s1_vl_r <= vld_i;
    end
    q1_r <= $signed(dq1_p - 32'h4000_0000);
    q2_r <= $signed(dq2_p - 32'h4000_0000);
  end

  // Square both quantities
  logic signed [63:0] sq1_p, sq2_p;
  logic [61:0]        sq1_r, sq2_r;
  logic signed [31:0] s2_q1_r, s2_q2_r;
  logic               s2_vl_r;

  always_comb begin
    sq1_p = q1_r * q1_r;
    sq2_p = q2_r * q2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vl_r <= 1'b0;
    end else begin
      s2_vl_r <= s1_vl_r;
    end
    sq1_r   <= sq1_p[61:0];
    sq2_r   <= sq2_p[61:0];
    s2_q1_r <= q1_r;
    s2_q2_r <= q2_r;
  end

  // Form 1-s for the root and 1-2s for x
  logic [61:0]        s_sum;
  logic signed [63:0] dd;
  logic [60:0]        dpos;
  logic signed [63:0] xv_nxt;
  logic [60:0]        s3_d_r;
  logic signed [63:0] s3_xv_r;
  logic signed [31:0] s3_q1_r, s3_q2_r;
  logic               s3_vl_r;

  always_comb begin
    s_sum  = sq1_r + sq2_r;
    dd     = 64'sh1000_0000_0000_0000 - $signed({2'b00, s_sum});
    dpos   = (dd > 64'sd0) ? dd[60:0] : '0;
    xv_nxt = 64'sh1000_0000_0000_0000 - $signed({1'b0, s_sum, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vl_r <= 1'b0;
    end else begin
      s3_vl_r <= s2_vl_r;
    end
    s3_d_r  <= dpos;
    s3_xv_r <= xv_nxt;
    s3_q1_r <= s2_q1_r;
    s3_q2_r <= s2_q2_r;
  end

  // Square root stages
  logic [60:0]        rt_v_in  [DEC_SQRT_STEPS];
  logic [60:0]        rt_r_in  [DEC_SQRT_STEPS];
  logic               rt_vl_in [DEC_SQRT_STEPS];
  logic signed [63:0] rt_x_in  [DEC_SQRT_STEPS];
  logic signed [31:0] rt_a_in  [DEC_SQRT_STEPS];
  logic signed [31:0] rt_b_in  [DEC_SQRT_STEPS];
  logic [60:0]        rt_v_r   [DEC_SQRT_STEPS];
  logic [60:0]        rt_r_r   [DEC_SQRT_STEPS];
  logic               rt_vl_r  [DEC_SQRT_STEPS];
  logic signed [63:0] rt_x_r   [DEC_SQRT_STEPS];
  logic signed [31:0] rt_a_r   [DEC_SQRT_STEPS];
  logic signed [31:0] rt_b_r   [DEC_SQRT_STEPS];

  for (genvar k = 0; k < DEC_SQRT_STEPS; k++) begin : g_rt
    localparam logic [60:0] BIT = 61'd1 << (60 - 2 * k);
    logic [60:0] trial;
    logic [60:0] v_nxt;
    logic [60:0] r_nxt;

    if (k == 0) begin : g_first
      assign rt_v_in[k]  = s3_d_r;
      assign rt_r_in[k]  = '0;
      assign rt_vl_in[k] = s3_vl_r;
      assign rt_x_in[k]  = s3_xv_r;
      assign rt_a_in[k]  = s3_q1_r;
      assign rt_b_in[k]  = s3_q2_r;
    end else begin : g_next
      assign rt_v_in[k]  = rt_v_r[k-1];
      assign rt_r_in[k]  = rt_r_r[k-1];
      assign rt_vl_in[k] = rt_vl_r[k-1];
      assign rt_x_in[k]  = rt_x_r[k-1];
      assign rt_a_in[k]  = rt_a_r[k-1];
      assign rt_b_in[k]  = rt_b_r[k-1];
    end

    // one root bit per stage
    always_comb begin
      trial = rt_r_in[k] + BIT;
      if (rt_v_in[k] >= trial) begin
        v_nxt = rt_v_in[k] - trial;
        r_nxt = (rt_r_in[k] >> 1) + BIT;
      end else begin
        v_nxt = rt_v_in[k];
        r_nxt = rt_r_in[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rt_vl_r[k] <= 1'b0;
      end else begin
        rt_vl_r[k] <= rt_vl_in[k];
      end
      rt_v_r[k] <= v_nxt;
      rt_r_r[k] <= r_nxt;
      rt_x_r[k] <= rt_x_in[k];
      rt_a_r[k] <= rt_a_in[k];
      rt_b_r[k] <= rt_b_in[k];
    end
  end

  // Scale by the root, round x
  logic [30:0]        root;
  logic signed [63:0] y_p, z_p;
  logic signed [63:0] s5_y_r, s5_z_r;
  logic [15:0]        s5_x_r;
  logic               s5_vl_r;

  always_comb begin
    root = rt_r_r[DEC_SQRT_STEPS-1][30:0];
    y_p  = rt_a_r[DEC_SQRT_STEPS-1] * $signed({1'b0, root});
    z_p  = rt_b_r[DEC_SQRT_STEPS-1] * $signed({1'b0, root});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vl_r <= 1'b0;
    end else begin
      s5_vl_r <= rt_vl_r[DEC_SQRT_STEPS-1];
    end
    s5_y_r <= y_p;
    s5_z_r <= z_p;
    s5_x_r <= to_q15(rt_x_r[DEC_SQRT_STEPS-1], 45);
  end

  // Round y and z
  logic [15:0] s6_x_r, s6_y_r, s6_z_r;
  logic        s6_vl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vl_r <= 1'b0;
    end else begin
      s6_vl_r <= s5_vl_r;
    end
    s6_x_r <= s5_x_r;
    s6_y_r <= to_q15(s5_y_r, 44);
    s6_z_r <= to_q15(s5_z_r, 44);
  end

  // Delay to match the encode path
  logic [15:0] pd_x_r  [DEC_PAD];
  logic [15:0] pd_y_r  [DEC_PAD];
  logic [15:0] pd_z_r  [DEC_PAD];
  logic        pd_vl_r [DEC_PAD];

  for (genvar i = 0; i < DEC_PAD; i++) begin : g_pd
    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          pd_vl_r[i] <= 1'b0;
        end else begin
          pd_vl_r[i] <= s6_vl_r;
        end
        pd_x_r[i] <= s6_x_r;
        pd_y_r[i] <= s6_y_r;
        pd_z_r[i] <= s6_z_r;
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          pd_vl_r[i] <= 1'b0;
        end else begin
          pd_vl_r[i] <= pd_vl_r[i-1];
        end
        pd_x_r[i] <= pd_x_r[i-1];
        pd_y_r[i] <= pd_y_r[i-1];
        pd_z_r[i] <= pd_z_r[i-1];
      end
    end
  end

  assign vld_o          = pd_vl_r[DEC_PAD-1];
  assign word_o.code_out = '0;
  assign word_o.out_x    = $signed(pd_x_r[DEC_PAD-1]);
  assign word_o.out_y    = $signed(pd_y_r[DEC_PAD-1]);
  assign word_o.out_z    = $signed(pd_z_r[DEC_PAD-1]);

endmodule

@@ rtl/core/unit_normal_pack_unpack.sv @@
// Unit normal pack/unpack: 16+16 bit Lambert azimuthal normal code.
// Throughput one word per cycle; out_strobe is registered after the encode pipeline.
// Latency is set by the 16-step root and 25-step reciprocal of the encode path.
// busy stays low: a word may start every cycle and out_strobe cannot be held.
// Synchronous active-low reset clears all valid bits; data registers are not reset.
module unit_normal_pack_unpack (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  unp_pkg::unp_in_t  in_word,
  output logic              out_strobe,
  output unp_pkg::unp_out_t out_word
);
  import unp_pkg::*;

  logic        accept;
  logic        enc_vld, enc_req, dec_vld;
  logic [31:0] enc_code;
  unp_out_t    dec_word;
  unp_out_t    word_nxt;
  logic        out_strobe_r;
  unp_out_t    out_word_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  unp_enc u_enc (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (accept),
    .in_i   (in_word),
    .vld_o  (enc_vld),
    .req_o  (enc_req),
    .code_o (enc_code)
  );

  unp_dec u_dec (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (accept),
    .code_i (in_word.packed_code),
    .vld_o  (dec_vld),
    .word_o (dec_word)
  );

  // Select the half that the request asked for
  always_comb begin
    if (enc_req == REQ_DECODE) begin
      word_nxt = dec_word;
    end else begin
      word_nxt          = '0;
      word_nxt.code_out = enc_code;
    end
  end

  // Register the result word and its strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= enc_vld;
    end
    out_word_r <= word_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  // Both paths must carry the same word at the same time
  a_paths_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    enc_vld == dec_vld)
    else $error("encode and decode pipelines out of step");

  // Every accepted word comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##44 out_strobe)
    else $error("accepted word did not come out");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |-> ##44 !out_strobe)
    else $error("strobe without an accepted word");

  // One of the two halves of a result is always zero
  a_half_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_word.code_out == '0) ||
      (out_word.out_x == '0 && out_word.out_y == '0 && out_word.out_z == '0))
    else $error("result carries both code and normal");

endmodule

@@ test/tb_unit_normal_pack_unpack.sv @@
// Testbench for unit_normal_pack_unpack: drives encode and decode words,
// predicts each result with a fixed-point model and checks every strobe.
// Depends on unp_pkg and the unit_normal_pack_unpack RTL.
`timescale 1ns / 1ps

import unp_pkg::*;

class normal_code_scoreboard;
  unp_out_t pending[$];
  int       errors;

  function logic [63:0] root64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] bit_w;
    r = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= r + bit_w) begin
        v = v - (r + bit_w);
        r = (r >> 1) + bit_w;
      end else begin
        r = r >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return r;
  endfunction

  // Round half up by 2^sh, saturate to Q1.15.
  function logic signed [15:0] round_q15(longint v, int sh);
    longint w;
    longint r;
    w = v + (longint'(1) << (sh - 1));
    if (w >= 0) r = w >>> sh;
    else r = -(((-w) + (longint'(1) << sh) - 1) >>> sh);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function logic [15:0] quant_half(longint comp, longint m);
    longint p;
    logic [63:0] u;
    p = comp * m;
    if (p > Q_CLAMP) p = Q_CLAMP;
    if (p < -Q_CLAMP) p = -Q_CLAMP;
    u = (p + (longint'(1) << 32)) * 32767;
    return u[47:32];
  endfunction

  function unp_out_t predict_pixel(unp_in_t w);
    unp_out_t    o;
    logic [63:0] t;
    logic [63:0] r;
    longint      m;
    longint      q1;
    longint      q2;
    longint      s;
    longint      d;
    longint      rt;
    o = '0;
    if (w.req_type == REQ_ENCODE) begin
      t = 64'(32768 + longint'(w.normal_x));
      r = root64(t << 16);
      m = (r != 0) ? longint'((64'd1 << 32) / r) : longint'(M_MAX);
      if (m > longint'(M_MAX)) m = M_MAX;
      o.code_out = {quant_half(longint'(w.normal_y), m), quant_half(longint'(w.normal_z), m)};
    end else begin
      q1 = longint'(w.packed_code[31:16]) * 32769 - (longint'(1) << 30);
      q2 = longint'(w.packed_code[15:0]) * 32769 - (longint'(1) << 30);
      s = q1 * q1 + q2 * q2;
      d = (longint'(1) << 60) - s;
      rt = (d > 0) ? longint'(root64(d)) : 0;
      o.out_x = round_q15((longint'(1) << 60) - 2 * s, 45);
      o.out_y = round_q15(q1 * rt, 44);
      o.out_z = round_q15(q2 * rt, 44);
    end
    return o;
  endfunction

  function void note_word(unp_in_t w);
    pending.push_back(predict_pixel(w));
  endfunction

  function void check_word(unp_out_t got);
    unp_out_t exp_w;
    if (pending.size() == 0) begin
      $error("unexpected result word %h", got);
      errors++;
      return;
    end
    exp_w = pending.pop_front();
    if (got.code_out !== exp_w.code_out) begin
      $error("code_out exp %h got %h", exp_w.code_out, got.code_out); errors++;
    end
    if (got.out_x !== exp_w.out_x) begin
      $error("out_x exp %0d got %0d", exp_w.out_x, got.out_x); errors++;
    end
    if (got.out_y !== exp_w.out_y) begin
      $error("out_y exp %0d got %0d", exp_w.out_y, got.out_y); errors++;
    end
    if (got.out_z !== exp_w.out_z) begin
      $error("out_z exp %0d got %0d", exp_w.out_z, got.out_z); errors++;
    end
  endfunction
endclass

module tb_unit_normal_pack_unpack;
  localparam int RANDOM_WORDS = 1030;
  localparam int CYCLE_LIMIT  = 200000;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  unp_in_t  in_word;
  logic     out_strobe;
  unp_out_t out_word;

  normal_code_scoreboard board;
  int cycles;
  int gaps_on;

  unit_normal_pack_unpack i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_word(in_word), .out_strobe(out_strobe), .out_word(out_word)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Check each strobed result word.
  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1) board.check_word(out_word);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Present one word, hold until accepted, then maybe idle a burst.
  task automatic send_word(unp_in_t w);
    int gap;
    start <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    board.note_word(w);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      start <= 1'b0;
      in_word <= '0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic unp_in_t enc_word(int x, int y, int z);
    unp_in_t w;
    w = '0;
    w.req_type = REQ_ENCODE;
    w.normal_x = 16'(x); w.normal_y = 16'(y); w.normal_z = 16'(z);
    return w;
  endfunction

  function automatic unp_in_t dec_word(logic [31:0] c);
    unp_in_t w;
    w = '0;
    w.req_type = REQ_DECODE;
    w.packed_code = c;
    return w;
  endfunction

  // Random word: mostly plausible unit normals and valid codes, some raw noise.
  function automatic unp_in_t random_word();
    unp_in_t w;
    real a;
    real b;
    int sel;
    sel = $urandom_range(0, 9);
    w = '0;
    if (sel < 2) begin
      w = 81'({$urandom, $urandom, $urandom});
      w.req_type = 1'($urandom_range(0, 1));
    end else if (sel < 6) begin
      a = ($urandom_range(0, 62831) / 10000.0);
      b = ($urandom_range(0, 31415) / 10000.0);
      w = enc_word(int'(32767.0 * $cos(b)), int'(32767.0 * $sin(b) * $cos(a)),
                   int'(32767.0 * $sin(b) * $sin(a)));
      w.packed_code = $urandom;
    end else begin
      w = dec_word({16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))});
      if ($urandom_range(0, 1)) w.packed_code = {16'($urandom_range(16000, 49000)),
                                                 16'($urandom_range(16000, 49000))};
      {w.normal_x, w.normal_y, w.normal_z} = 48'({$urandom, $urandom});
    end
    return w;
  endfunction

  initial begin
    board = new();
    cycles = 0;
    gaps_on = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, the -x pole, non-unit normals, saturating codes.
    send_word(enc_word(32767, 0, 0));
    send_word(enc_word(-32768, 0, 0));
    send_word(enc_word(-32768, 5, -5));
    send_word(enc_word(-32768, 32767, -32768));
    send_word(enc_word(0, 23170, 23170));
    send_word(enc_word(0, -23170, -23170));
    send_word(enc_word(-32767, 32767, 32767));
    send_word(enc_word(32767, 32767, -32768));
    send_word(enc_word(-1, -1, -1));
    send_word(enc_word(0, 0, 0));
    send_word(dec_word(32'h7FFF_7FFF));
    send_word(dec_word(32'h0000_0000));
    send_word(dec_word(32'hFFFF_FFFF));
    send_word(dec_word(32'hFFFE_7FFF));
    send_word(dec_word(32'h7FFF_FFFE));
    send_word(dec_word(32'h0000_FFFF));
    send_word(dec_word(32'hC000_4000));
    send_word(dec_word(32'h5A82_5A82));
    send_word(dec_word(32'h8001_7FFE));
    send_word({1'b0, 16'h5555, 16'hAAAA, 16'h5555, 32'hAAAA_5555});

    // Random words with idle bursts, then a final stretch at full rate.
    gaps_on = 1;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS - 150) gaps_on = 0;
      send_word(random_word());
    end
    start <= 1'b0;
    in_word <= '0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (board.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
